// ===== rtl/core/onewire_temp_sensor_reader_core_macros.svh =====
// Assertion macros for the 1-Wire temperature reader core.
// Used by the top level; relies on signals named clk and rst_n in scope.
`ifndef ONEWIRE_TEMP_SENSOR_READER_CORE_MACROS_SVH
`define ONEWIRE_TEMP_SENSOR_READER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OWTSR_ASSERT_NOW(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("owtsr assertion failed");
`define OWTSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owtsr assertion failed");
`else
`define OWTSR_ASSERT_NOW(label, prop)
`define OWTSR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/owtsr_pkg.sv =====
// Types and constants shared by the 1-Wire temperature reader core.
// No dependencies.
package owtsr_pkg;

    localparam int US_W   = 10;
    localparam int POLL_W = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_POLL_LIMIT      = 2'd0,
        CFG_RESET_LOW       = 2'd1,
        CFG_PRESENCE_SAMPLE = 2'd2,
        CFG_PRESENCE_TAIL   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_PRESENCE = 2'd1,
        ST_TIMEOUT     = 2'd2
    } status_t;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [US_W-1:0] WR_SLOT_US = 10'd58;
    localparam logic [US_W-1:0] WR_REC_US  = 10'd2;
    localparam logic [US_W-1:0] WR_GAP_US  = 10'd98;
    localparam logic [US_W-1:0] RD_WAIT_US = 10'd10;
    localparam logic [US_W-1:0] RD_TAIL_US = 10'd45;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RST      = 16'd1000;
    localparam logic [US_W-1:0]   RESET_LOW_RST       = 10'd478;
    localparam logic [7:0]        PRESENCE_SAMPLE_RST = 8'd54;
    localparam logic [US_W-1:0]   PRESENCE_TAIL_RST   = 10'd423;

    typedef struct packed {
        logic [POLL_W-1:0] poll_limit;
        logic [US_W-1:0]   reset_low_us;
        logic [7:0]        presence_sample_us;
        logic [US_W-1:0]   presence_tail_us;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        status_t     status;
        logic [15:0] temperature_raw;
    } res_t;

endpackage

// ===== rtl/core/owtsr_if.sv =====
// Handshake channels of the 1-Wire temperature reader core.
// Depends on nothing; payload widths follow the block's fields.
interface owtsr_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic bus_level;

    modport source (output valid, output start_req, output bus_level, input ready);
    modport sink (input valid, input start_req, input bus_level, output ready);
endinterface

interface owtsr_result_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] temperature_raw;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output temperature_raw, input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input status, input temperature_raw, output ready);
endinterface

// ===== rtl/core/owtsr_cfg.sv =====
// Configuration registers of the 1-Wire temperature reader core.
// Depends on owtsr_pkg.
module owtsr_cfg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  owtsr_pkg::cfg_idx_t    cfg_index,
    input  logic [owtsr_pkg::CFG_W-1:0] cfg_data,
    output owtsr_pkg::cfg_t        cfg
);
    import owtsr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_limit         <= POLL_LIMIT_RST;
            cfg_reg.reset_low_us       <= RESET_LOW_RST;
            cfg_reg.presence_sample_us <= PRESENCE_SAMPLE_RST;
            cfg_reg.presence_tail_us   <= PRESENCE_TAIL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_LIMIT:      cfg_reg.poll_limit         <= cfg_data;
                CFG_RESET_LOW:       cfg_reg.reset_low_us       <= cfg_data[US_W-1:0];
                CFG_PRESENCE_SAMPLE: cfg_reg.presence_sample_us <= cfg_data[7:0];
                CFG_PRESENCE_TAIL:   cfg_reg.presence_tail_us   <= cfg_data[US_W-1:0];
                default:             cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== rtl/core/owtsr_seq.sv =====
// Bus sequencer: phase, slot timer, bit shifter and poll budget, one step per tick.
// Depends on owtsr_pkg.
module owtsr_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              start_req,
    input  logic              bus_level,
    input  owtsr_pkg::cfg_t   cfg,
    output owtsr_pkg::res_t   res
);
    import owtsr_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_RST_PRE  = 5'd1,
        PH_RST_LOW  = 5'd2,
        PH_RST_REL  = 5'd3,
        PH_RST_TAIL = 5'd4,
        PH_WR_LOW   = 5'd5,
        PH_WR_SLOT  = 5'd6,
        PH_WR_REC   = 5'd7,
        PH_WR_GAP   = 5'd8,
        PH_RD_LOW   = 5'd9,
        PH_RD_WAIT  = 5'd10,
        PH_RD_TAIL  = 5'd11
    } phase_t;

    typedef enum logic [2:0] {
        SG_CC1   = 3'd0,
        SG_CONV  = 3'd1,
        SG_CC2   = 3'd2,
        SG_RDPAD = 3'd3,
        SG_POLL  = 3'd4,
        SG_LSB   = 3'd5,
        SG_MSB   = 3'd6
    } stage_t;

    phase_t            phase_reg, phase_next;
    logic [US_W-1:0]   us_reg, us_next;
    logic [2:0]        bit_reg, bit_next;
    stage_t            stage_reg, stage_next;
    logic [7:0]        shift_reg, shift_next;
    logic [POLL_W-1:0] polls_reg, polls_next;
    logic [7:0]        low_reg, low_next;
    logic [15:0]       temp_reg, temp_next;

    logic [US_W-1:0]   dur;
    logic [US_W-1:0]   dur_eff;
    logic [US_W-1:0]   us_inc;
    logic              over;
    logic [US_W-1:0]   us_after;
    logic [7:0]        pres_byte;
    logic [7:0]        rd_byte;

    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:  dur = cfg.reset_low_us;
            PH_RST_REL:  dur = {{(US_W-8){1'b0}}, cfg.presence_sample_us};
            PH_RST_TAIL: dur = cfg.presence_tail_us;
            PH_WR_SLOT:  dur = WR_SLOT_US;
            PH_WR_REC:   dur = WR_REC_US;
            PH_WR_GAP:   dur = WR_GAP_US;
            PH_RD_WAIT:  dur = RD_WAIT_US;
            PH_RD_TAIL:  dur = RD_TAIL_US;
            default:     dur = {{(US_W-1){1'b0}}, 1'b1};
        endcase
        dur_eff  = (dur == '0) ? {{(US_W-1){1'b0}}, 1'b1} : dur;
        us_inc   = us_reg + {{(US_W-1){1'b0}}, 1'b1};
        over     = (us_inc >= dur_eff);
        us_after = over ? '0 : us_inc;
        pres_byte = (us_reg == '0) ? {7'd0, bus_level} : shift_reg;
        rd_byte   = (us_reg == '0) ? {bus_level, shift_reg[7:1]} : shift_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        us_next    = us_reg;
        bit_next   = bit_reg;
        stage_next = stage_reg;
        shift_next = shift_reg;
        polls_next = polls_reg;
        low_next   = low_reg;
        temp_next  = temp_reg;
        res.drive_low       = 1'b0;
        res.busy_res        = (phase_reg != PH_IDLE);
        res.done_res        = 1'b0;
        res.status          = ST_OK;
        res.temperature_raw = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    res.busy_res = 1'b1;
                    polls_next   = cfg.poll_limit;
                    stage_next   = SG_CC1;
                    phase_next   = PH_RST_LOW;
                    us_next      = '0;
                end
            end
            PH_RST_PRE:
            begin
                phase_next = PH_RST_LOW;
                us_next    = '0;
            end
            PH_RST_LOW:
            begin
                res.drive_low = 1'b1;
                us_next       = us_after;
                if (over)
                begin
                    phase_next = PH_RST_REL;
                end
            end
            PH_RST_REL:
            begin
                us_next = us_after;
                if (over)
                begin
                    phase_next = PH_RST_TAIL;
                end
            end
            PH_RST_TAIL:
            begin
                shift_next = pres_byte;
                us_next    = us_after;
                if (over)
                begin
                    if (pres_byte[0])
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_NO_PRESENCE;
                        phase_next   = PH_IDLE;
                    end
                    else
                    begin
                        shift_next = CMD_SKIP_ROM;
                        bit_next   = '0;
                        phase_next = PH_WR_LOW;
                    end
                end
            end
            PH_WR_LOW:
            begin
                res.drive_low = 1'b1;
                phase_next    = PH_WR_SLOT;
                us_next       = '0;
            end
            PH_WR_SLOT:
            begin
                res.drive_low = !shift_reg[0];
                us_next       = us_after;
                if (over)
                begin
                    phase_next = PH_WR_REC;
                end
            end
            PH_WR_REC:
            begin
                us_next = us_after;
                if (over)
                begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (bit_reg == 3'd7)
                    begin
                        phase_next = PH_WR_GAP;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_WR_LOW;
                    end
                end
            end
            PH_WR_GAP:
            begin
                us_next = us_after;
                if (over)
                begin
                    bit_next = '0;
                    unique case (stage_reg)
                        SG_CC1:
                        begin
                            stage_next = SG_CONV;
                            shift_next = CMD_CONVERT;
                            phase_next = PH_WR_LOW;
                        end
                        SG_CONV:
                        begin
                            stage_next = SG_POLL;
                            shift_next = '0;
                            phase_next = PH_RD_LOW;
                        end
                        SG_CC2:
                        begin
                            stage_next = SG_RDPAD;
                            shift_next = CMD_READ_PAD;
                            phase_next = PH_WR_LOW;
                        end
                        SG_RDPAD:
                        begin
                            stage_next = SG_LSB;
                            shift_next = '0;
                            phase_next = PH_RD_LOW;
                        end
                        default:
                        begin
                            bit_next   = bit_reg;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_RD_LOW:
            begin
                res.drive_low = 1'b1;
                phase_next    = PH_RD_WAIT;
                us_next       = '0;
            end
            PH_RD_WAIT:
            begin
                us_next = us_after;
                if (over)
                begin
                    phase_next = PH_RD_TAIL;
                end
            end
            PH_RD_TAIL:
            begin
                shift_next = rd_byte;
                us_next    = us_after;
                if (over)
                begin
                    if (bit_reg != 3'd7)
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_RD_LOW;
                    end
                    else
                    begin
                        unique case (stage_reg)
                            SG_POLL:
                            begin
                                priority if (rd_byte != '0)
                                begin
                                    stage_next = SG_CC2;
                                    phase_next = PH_RST_PRE;
                                end
                                else if (polls_reg <= {{(POLL_W-1){1'b0}}, 1'b1})
                                begin
                                    polls_next   = '0;
                                    res.done_res = 1'b1;
                                    res.status   = ST_TIMEOUT;
                                    phase_next   = PH_IDLE;
                                end
                                else
                                begin
                                    polls_next = polls_reg - {{(POLL_W-1){1'b0}}, 1'b1};
                                    shift_next = '0;
                                    bit_next   = '0;
                                    phase_next = PH_RD_LOW;
                                end
                            end
                            SG_LSB:
                            begin
                                low_next   = rd_byte;
                                stage_next = SG_MSB;
                                shift_next = '0;
                                bit_next   = '0;
                                phase_next = PH_RD_LOW;
                            end
                            SG_MSB:
                            begin
                                temp_next           = {rd_byte, low_reg};
                                res.done_res        = 1'b1;
                                res.temperature_raw = {rd_byte, low_reg};
                                phase_next          = PH_IDLE;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                res.busy_res = 1'b0;
                phase_next   = PH_IDLE;
                us_next      = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            us_reg    <= '0;
            bit_reg   <= '0;
            stage_reg <= SG_CC1;
            shift_reg <= '0;
            polls_reg <= '0;
            low_reg   <= '0;
            temp_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            us_reg    <= us_next;
            bit_reg   <= bit_next;
            stage_reg <= stage_next;
            shift_reg <= shift_next;
            polls_reg <= polls_next;
            low_reg   <= low_next;
            temp_reg  <= temp_next;
        end
    end
endmodule

// ===== rtl/core/owtsr_out.sv =====
// Result register between the sequencer and the result channel.
// Depends on owtsr_pkg and owtsr_if.
module owtsr_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  owtsr_pkg::res_t  res,
    output logic             room,
    owtsr_result_if.source   result
);
    import owtsr_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign room = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign result.valid           = valid_reg;
    assign result.drive_low       = res_reg.drive_low;
    assign result.busy_res        = res_reg.busy_res;
    assign result.done_res        = res_reg.done_res;
    assign result.status          = res_reg.status;
    assign result.temperature_raw = res_reg.temperature_raw;
endmodule

// ===== rtl/core/onewire_temp_sensor_reader_core.sv =====
// Top level of the 1-Wire temperature reader: config, sequencer, result register.
// Depends on owtsr_pkg, owtsr_if, owtsr_cfg, owtsr_seq, owtsr_out and the macro header.
//
//   channel   dir   word
//   tick      in    start_req, bus_level (one microsecond tick)
//   result    out   drive_low, busy_res, done_res, status, temperature_raw
//   cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// One tick enters per clock unless stalled; its word is registered for the next cycle.
// The sequencer step and the result register load together.
// A stalled result holds the tick channel only while the result register is full.
// Reset clears the sequencer to idle and loads register defaults; no clearing pass.
`include "onewire_temp_sensor_reader_core_macros.svh"
module onewire_temp_sensor_reader_core (
    input  logic                        clk,
    input  logic                        rst_n,
    owtsr_tick_if.sink                  tick,
    owtsr_result_if.source              result,
    input  logic                        cfg_we,
    input  owtsr_pkg::cfg_idx_t         cfg_index,
    input  logic [owtsr_pkg::CFG_W-1:0] cfg_data
);
    import owtsr_pkg::*;

    cfg_t cfg;
    res_t res;
    logic room;
    logic step;

    assign tick.ready = room;
    assign step       = tick.valid && room;

    owtsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owtsr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .start_req (tick.start_req),
        .bus_level (tick.bus_level),
        .cfg       (cfg),
        .res       (res)
    );

    owtsr_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .res    (res),
        .room   (room),
        .result (result)
    );

    `OWTSR_ASSERT_NEXT(a_step_loads, step, result.valid)
    `OWTSR_ASSERT_NOW(a_done_busy, !(result.valid && result.done_res) || result.busy_res)
    `OWTSR_ASSERT_NOW(a_status_done, !(result.valid && result.status != ST_OK) || result.done_res)
    `OWTSR_ASSERT_NOW(a_temp_ok, !(result.valid && result.temperature_raw != '0) ||
                      (result.done_res && result.status == ST_OK))
endmodule

// ===== verif/onewire_read_checker.sv =====
// Checker for the 1-Wire temperature reader core: watches the tick, result and config ports,
// predicts each result word from its own copy of the sequencer, and counts mismatches.
// Depends on owtsr_pkg and the owtsr_tick_if / owtsr_result_if interfaces.
module onewire_read_checker
    import owtsr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    owtsr_tick_if               tick,
    owtsr_result_if             result,
    input  logic                cfg_we,
    input  cfg_idx_t            cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                run_over,
    output int                  mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        P_IDLE,
        P_RST_PRE,
        P_RST_LOW,
        P_RST_REL,
        P_RST_TAIL,
        P_WR_LOW,
        P_WR_SLOT,
        P_WR_REC,
        P_WR_GAP,
        P_RD_LOW,
        P_RD_WAIT,
        P_RD_TAIL
    } bus_phase_t;

    typedef enum logic [2:0] {
        STG_CC1,
        STG_CONV,
        STG_CC2,
        STG_RDPAD,
        STG_POLL,
        STG_LSB,
        STG_MSB
    } read_stage_t;

    logic [POLL_W-1:0] poll_lim;
    logic [US_W-1:0]   rst_low;
    logic [7:0]        pres_smp;
    logic [US_W-1:0]   pres_tail;

    bus_phase_t        phase;
    read_stage_t       stage;
    logic [US_W-1:0]   us_cnt;
    logic [2:0]        bit_idx;
    logic [7:0]        sbyte;
    logic [POLL_W-1:0] polls;
    logic [7:0]        lo_byte;
    logic [15:0]       temp_word;
    logic              ended;
    status_t           end_code;

    res_t pending_words[$];
    bit   leftovers_checked;

    function automatic void go(input bus_phase_t p);
        phase  = p;
        us_cnt = '0;
    endfunction

    function automatic logic slot_elapsed(input logic [US_W-1:0] dur);
        logic [US_W-1:0] lim;
        lim    = (dur == '0) ? 10'd1 : dur;
        us_cnt = us_cnt + 10'd1;
        if (us_cnt >= lim)
        begin
            us_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void end_transfer(input status_t code);
        ended    = 1'b1;
        end_code = code;
        go(P_IDLE);
    endfunction

    function automatic void send_byte(input logic [7:0] b);
        sbyte   = b;
        bit_idx = '0;
        go(P_WR_LOW);
    endfunction

    function automatic void recv_byte();
        sbyte   = '0;
        bit_idx = '0;
        go(P_RD_LOW);
    endfunction

    function automatic void byte_sent();
        case (stage)
            STG_CC1:
            begin
                stage = STG_CONV;
                send_byte(CMD_CONVERT);
            end
            STG_CONV:
            begin
                stage = STG_POLL;
                recv_byte();
            end
            STG_CC2:
            begin
                stage = STG_RDPAD;
                send_byte(CMD_READ_PAD);
            end
            STG_RDPAD:
            begin
                stage = STG_LSB;
                recv_byte();
            end
            default: go(P_IDLE);
        endcase
    endfunction

    function automatic void byte_received();
        case (stage)
            STG_POLL:
            begin
                if (sbyte != 8'd0)
                begin
                    stage = STG_CC2;
                    go(P_RST_PRE);
                end
                else if (polls <= 16'd1)
                begin
                    polls = '0;
                    end_transfer(ST_TIMEOUT);
                end
                else
                begin
                    polls = polls - 16'd1;
                    recv_byte();
                end
            end
            STG_LSB:
            begin
                lo_byte = sbyte;
                stage   = STG_MSB;
                recv_byte();
            end
            STG_MSB:
            begin
                temp_word = {sbyte, lo_byte};
                end_transfer(ST_OK);
            end
            default: go(P_IDLE);
        endcase
    endfunction

    function automatic res_t next_word(input logic start, input logic bus);
        res_t r;
        r          = '0;
        ended      = 1'b0;
        end_code   = ST_OK;
        r.busy_res = (phase != P_IDLE);
        case (phase)
            P_IDLE:
            begin
                if (start)
                begin
                    r.busy_res = 1'b1;
                    polls      = poll_lim;
                    stage      = STG_CC1;
                    go(P_RST_LOW);
                end
            end
            P_RST_PRE: go(P_RST_LOW);
            P_RST_LOW:
            begin
                r.drive_low = 1'b1;
                if (slot_elapsed(rst_low))
                    go(P_RST_REL);
            end
            P_RST_REL:
            begin
                if (slot_elapsed({2'b00, pres_smp}))
                    go(P_RST_TAIL);
            end
            P_RST_TAIL:
            begin
                if (us_cnt == '0)
                    sbyte = {7'd0, bus};
                if (slot_elapsed(pres_tail))
                begin
                    if (sbyte[0])
                        end_transfer(ST_NO_PRESENCE);
                    else
                        send_byte(CMD_SKIP_ROM);
                end
            end
            P_WR_LOW:
            begin
                r.drive_low = 1'b1;
                go(P_WR_SLOT);
            end
            P_WR_SLOT:
            begin
                r.drive_low = ~sbyte[0];
                if (slot_elapsed(WR_SLOT_US))
                    go(P_WR_REC);
            end
            P_WR_REC:
            begin
                if (slot_elapsed(WR_REC_US))
                begin
                    sbyte = sbyte >> 1;
                    if (bit_idx >= 3'd7)
                        go(P_WR_GAP);
                    else
                    begin
                        bit_idx = bit_idx + 3'd1;
                        go(P_WR_LOW);
                    end
                end
            end
            P_WR_GAP:
            begin
                if (slot_elapsed(WR_GAP_US))
                    byte_sent();
            end
            P_RD_LOW:
            begin
                r.drive_low = 1'b1;
                go(P_RD_WAIT);
            end
            P_RD_WAIT:
            begin
                if (slot_elapsed(RD_WAIT_US))
                    go(P_RD_TAIL);
            end
            P_RD_TAIL:
            begin
                if (us_cnt == '0)
                    sbyte = {bus, sbyte[7:1]};
                if (slot_elapsed(RD_TAIL_US))
                begin
                    if (bit_idx >= 3'd7)
                        byte_received();
                    else
                    begin
                        bit_idx = bit_idx + 3'd1;
                        go(P_RD_LOW);
                    end
                end
            end
            default:
            begin
                r.busy_res = 1'b0;
                go(P_IDLE);
            end
        endcase
        r.done_res        = ended;
        r.status          = ended ? end_code : ST_OK;
        r.temperature_raw = (ended && end_code == ST_OK) ? temp_word : 16'd0;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            poll_lim  = POLL_LIMIT_RST;
            rst_low   = RESET_LOW_RST;
            pres_smp  = PRESENCE_SAMPLE_RST;
            pres_tail = PRESENCE_TAIL_RST;
            phase     = P_IDLE;
            stage     = STG_CC1;
            us_cnt    = '0;
            bit_idx   = '0;
            sbyte     = '0;
            polls     = '0;
            lo_byte   = '0;
            temp_word = '0;
            mismatches = 0;
            leftovers_checked = 1'b0;
            pending_words.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLL_LIMIT:      poll_lim  = cfg_data;
                    CFG_RESET_LOW:       rst_low   = cfg_data[US_W-1:0];
                    CFG_PRESENCE_SAMPLE: pres_smp  = cfg_data[7:0];
                    CFG_PRESENCE_TAIL:   pres_tail = cfg_data[US_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("result word arrived with none expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    check_field("drive_low", 16'(want.drive_low), 16'(result.drive_low));
                    check_field("busy_res", 16'(want.busy_res), 16'(result.busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(result.done_res));
                    check_field("status", 16'(want.status), 16'(result.status));
                    check_field("temperature_raw", want.temperature_raw,
                                result.temperature_raw);
                end
            end
            if (tick.valid && tick.ready)
                pending_words.push_back(next_word(tick.start_req, tick.bus_level));
            if (run_over && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (pending_words.size() != 0)
                begin
                    $error("%0d result words never arrived", pending_words.size());
                    mismatches++;
                end
            end
        end
    end

endmodule

// ===== verif/onewire_temp_sensor_reader_core_test.sv =====
// Top of the 1-Wire temperature reader test: clock, reset, tick stimulus, result stalls,
// register programming between transfers, and the verdict.
// Depends on owtsr_pkg, the owtsr interfaces, onewire_read_checker and the core.
module onewire_temp_sensor_reader_core_test;
    import owtsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             run_over;
    int               mismatches;

    int  ticks_sent = 0;
    int  words_seen = 0;
    int  dones      = 0;
    bit  last_idle  = 1'b1;
    bit  calm       = 1'b0;
    bit  held_long  = 1'b0;

    owtsr_tick_if   tick_ch();
    owtsr_result_if result_ch();

    onewire_temp_sensor_reader_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    onewire_read_checker read_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .run_over   (run_over),
        .mismatches (mismatches)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (tick_ch.valid && tick_ch.ready)
            ticks_sent <= ticks_sent + 1;
        if (result_ch.valid && result_ch.ready)
        begin
            words_seen <= words_seen + 1;
            last_idle  <= !result_ch.busy_res || result_ch.done_res;
            if (result_ch.done_res)
                dones <= dones + 1;
        end
    end

    function automatic logic bus_bit(input int low_pct);
        return ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
    endfunction

    function automatic logic [15:0] pick_len();
        return {6'($urandom_range(63)), 10'($urandom_range(9))};
    endfunction

    // Call at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_tick(input logic start, input logic bus);
        if (!calm && $urandom_range(15) == 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(negedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.start_req <= start;
        tick_ch.bus_level <= bus;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [15:0] poll, input logic [15:0] low_us,
                                input logic [15:0] smp_us, input logic [15:0] tail_us);
        cfg_idx_t    idx_list[4];
        logic [15:0] vals[4];
        idx_list = '{CFG_POLL_LIMIT, CFG_RESET_LOW, CFG_PRESENCE_SAMPLE, CFG_PRESENCE_TAIL};
        vals     = '{poll, low_us, smp_us, tail_us};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Run until n_done transfers end, then drain with no start until the core is idle.
    task automatic run_session(input int low_pct, input int n_done);
        int target;
        target = dones + n_done;
        while (dones < target)
            send_tick($urandom_range(3) == 0, bus_bit(low_pct));
        while (!(ticks_sent == words_seen && last_idle))
        begin
            if (ticks_sent != words_seen)
            begin
                tick_ch.valid <= 1'b0;
                @(negedge clk);
            end
            else
                send_tick(1'b0, bus_bit(low_pct));
        end
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm && !held_long && words_seen >= 100 && tick_ch.valid)
            begin
                held_long = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (200) @(negedge clk);
            end
            else if (!calm && $urandom_range(15) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 1)) @(negedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.start_req = 1'b0;
        tick_ch.bus_level = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_POLL_LIMIT;
        cfg_data          = '0;
        run_over          = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        repeat (9)
            send_tick(1'b1, 1'b1);
        run_session(0, 1);

        program_regs(16'd1, 16'd1, 16'd1, 16'd3);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        run_session(0, 1);

        for (int s = 0; s < 8; s++)
        begin
            program_regs(16'($urandom), pick_len(), pick_len(), pick_len());
            run_session(0, 2);
        end

        calm = 1'b1;
        program_regs(16'd2, 16'd3, 16'd2, 16'd4);
        send_tick(1'b1, 1'b0);
        for (int i = 1; i < 230; i++)
            send_tick(1'b0, (i < 10) ? 1'b0 : bus_bit(50));
        tick_ch.valid <= 1'b0;
        while (ticks_sent != words_seen)
            @(negedge clk);

        run_over <= 1'b1;
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/owtsr_pkg.sv
rtl/core/owtsr_if.sv
rtl/core/owtsr_cfg.sv
rtl/core/owtsr_seq.sv
rtl/core/owtsr_out.sv
rtl/core/onewire_temp_sensor_reader_core.sv
verif/onewire_read_checker.sv
verif/onewire_temp_sensor_reader_core_test.sv
